/* hdl/cfsc_pkg.sv */
// ----------------------------------------------------------------------------
// cfsc_pkg
// Shared types, constants and helpers for the signature classifier.
// ----------------------------------------------------------------------------
package cfsc_pkg;

  localparam int WindowBytes = 4096;
  localparam int HeadBytes   = 13;
  localparam int CountW      = 13;
  localparam int HeadIdxW    = $clog2(HeadBytes);
  localparam int CodeW       = 4;
  localparam int OutTdataW   = 24;
  localparam int OutPadW     = OutTdataW - CodeW - CountW;

  // "shar" as it sits in a 32-bit window, oldest byte highest
  localparam logic [31:0] SharWord     = 32'h7368_6172;
  localparam logic [7:0]  LzmaPropsMax = 8'd224;
  localparam logic [31:0] LzmaDictMin  = 32'h0000_1000;
  localparam logic [31:0] LzmaDictMax  = 32'h0800_0000;

  typedef logic [2:0] uu_state_t;
  localparam uu_state_t UuSkip = 3'd0;
  localparam uu_state_t UuDone = 3'd6;
  localparam uu_state_t UuFail = 3'd7;

  typedef enum logic [CodeW-1:0] {
    FMT_NONE  = 4'd0,
    FMT_GZIP  = 4'd1,
    FMT_BZIP2 = 4'd2,
    FMT_XZ    = 4'd3,
    FMT_LZIP  = 4'd4,
    FMT_LZ4   = 4'd5,
    FMT_LZMA  = 4'd6,
    FMT_LZOP  = 4'd7,
    FMT_SHAR  = 4'd8,
    FMT_UUENC = 4'd9,
    FMT_AR    = 4'd10,
    FMT_CPIO  = 4'd11
  } fmt_t;

  typedef logic [HeadBytes-1:0][7:0] head_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    head_t             head;
    logic [23:0]       recent;
    logic              shar_seen;
    uu_state_t         uu_state;
  } scan_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
  endfunction

  // expected character of "begin " at each matched position
  function automatic logic [7:0] uu_char(input uu_state_t idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h62;
      3'd1: c = 8'h65;
      3'd2: c = 8'h67;
      3'd3: c = 8'h69;
      3'd4: c = 8'h6e;
      3'd5: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hdl/cfsc_match.sv */
// ----------------------------------------------------------------------------
// cfsc_match
// Priority classifier over the scan state of one file head.
// ----------------------------------------------------------------------------
module cfsc_match import cfsc_pkg::*; (
  input  scan_t            snap,
  output logic [CodeW-1:0] format_code
);

  head_t             h;
  logic [CountW-1:0] n;
  logic [31:0]       dict;
  logic              is_gzip, is_bzh, is_xz, is_lzip, is_lz4, is_lzma;
  logic              is_lzop, is_shar, is_uu, is_ar, is_cpio;

  assign h    = snap.head;
  assign n    = snap.count;
  assign dict = {h[4], h[3], h[2], h[1]};

  assign is_gzip  = (n >= CountW'(2)) && h[0] == 8'h1f && h[1] == 8'h8b;
  assign is_bzh   = (n >= CountW'(3)) && h[0] == 8'h42 && h[1] == 8'h5a && h[2] == 8'h68;
  assign is_xz    = (n >= CountW'(6)) && h[0] == 8'hfd && h[1] == 8'h37 && h[2] == 8'h7a
                    && h[3] == 8'h58 && h[4] == 8'h5a && h[5] == 8'h00;
  assign is_lzip  = (n >= CountW'(4)) && h[0] == 8'h4c && h[1] == 8'h5a && h[2] == 8'h49
                    && h[3] == 8'h50;
  assign is_lz4   = (n >= CountW'(4)) && h[0] == 8'h04 && h[1] == 8'h22 && h[2] == 8'h4d
                    && h[3] == 8'h18;
  assign is_lzma  = (n >= CountW'(13)) && h[0] <= LzmaPropsMax
                    && dict >= LzmaDictMin && dict <= LzmaDictMax;
  assign is_lzop  = (n >= CountW'(9)) && h[0] == 8'h89 && h[1] == 8'h4c && h[2] == 8'h5a
                    && h[3] == 8'h4f && h[4] == 8'h00 && h[5] == 8'h0d && h[6] == 8'h0a
                    && h[7] == 8'h1a && h[8] == 8'h0a;
  assign is_shar  = (n >= CountW'(10)) && h[0] == 8'h23 && h[1] == 8'h21 && snap.shar_seen;
  assign is_uu    = (snap.uu_state == UuDone);
  assign is_ar    = (n >= CountW'(8)) && h[0] == 8'h21 && h[1] == 8'h3c && h[2] == 8'h61
                    && h[3] == 8'h72 && h[4] == 8'h63 && h[5] == 8'h68 && h[6] == 8'h3e
                    && h[7] == 8'h0a;
  assign is_cpio  = (n >= CountW'(6)) && h[0] == 8'h30 && h[1] == 8'h37 && h[2] == 8'h30
                    && h[3] == 8'h37 && h[4] == 8'h30 && h[5] == 8'h31;

  always_comb begin
    if (is_gzip)       format_code = FMT_GZIP;
    else if (is_bzh)   format_code = FMT_BZIP2;
    else if (is_xz)    format_code = FMT_XZ;
    else if (is_lzip)  format_code = FMT_LZIP;
    else if (is_lz4)   format_code = FMT_LZ4;
    else if (is_lzma)  format_code = FMT_LZMA;
    else if (is_lzop)  format_code = FMT_LZOP;
    else if (is_shar)  format_code = FMT_SHAR;
    else if (is_uu)    format_code = FMT_UUENC;
    else if (is_ar)    format_code = FMT_AR;
    else if (is_cpio)  format_code = FMT_CPIO;
    else               format_code = FMT_NONE;
  end

endmodule

/* hdl/compressed_format_signature_classifier_core.sv */
// ----------------------------------------------------------------------------
// compressed_format_signature_classifier_core
// Names the archive/compression format of a file head streamed one byte
// per request; one result request per end-of-file marker.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Fields (tdata/tuser/tlast)
// --------+-----+-----------------------------------------------------------
// s_*     | in  | tdata[7:0] data_byte, tuser byte_present, tlast end_of_file
// m_*     | out | tdata[3:0] format_code, tdata[16:4] bytes_examined
//
// One input request per cycle while no end-of-file request stalls. A request
// is held in the input register; the scan state update and the classifier
// form a single combinational pass into the scan and result registers, so a
// result reaches m_tvalid from the input register through the result register.
// rst (synchronous) empties both registers and clears the scan state.
// Only a request carrying end_of_file waits on a full, stalled result
// register; bytes keep streaming while a result waits to be taken.
// ----------------------------------------------------------------------------
module compressed_format_signature_classifier_core import cfsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] data_byte
  input  logic                 s_tuser,   // byte_present
  input  logic                 s_tlast,   // end_of_file
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutTdataW-1:0] m_tdata    // [3:0] format_code, [16:4] bytes_examined
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_present;
  logic       in_eof;

  // scan state and result register
  scan_t             scan;
  scan_t             snap;       // state with the current byte taken in
  scan_t             scan_next;
  logic              out_valid;
  logic [CodeW-1:0]  out_code;
  logic [CountW-1:0] out_count;
  logic [CodeW-1:0]  code;

  logic        take;
  logic        advance;
  logic [31:0] last4;

  // an end marker needs room in the result register; plain bytes never wait
  assign advance  = in_valid && (!in_eof || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  assign take  = in_valid && in_present && (scan.count < CountW'(WindowBytes));
  assign last4 = {scan.recent, in_byte};

  // take the byte into the scan state
  always_comb begin
    snap = scan;
    if (take) begin
      if (scan.count < CountW'(HeadBytes)) begin
        snap.head[scan.count[HeadIdxW-1:0]] = in_byte;
      end
      if (scan.count >= CountW'(3) && last4 == SharWord) begin
        snap.shar_seen = 1'b1;
      end
      snap.recent = last4[23:0];
      // "begin " after any leading whitespace
      if (scan.uu_state == UuSkip) begin
        if (!is_space(in_byte)) begin
          snap.uu_state = (in_byte == uu_char(UuSkip)) ? 3'd1 : UuFail;
        end
      end else if (scan.uu_state < UuDone) begin
        snap.uu_state = (in_byte == uu_char(scan.uu_state)) ? scan.uu_state + 3'd1 : UuFail;
      end
      snap.count = scan.count + CountW'(1);
    end
  end

  cfsc_match u_match (
    .snap        (snap),
    .format_code (code)
  );

  // after a result the scan starts over; head bytes are simply overwritten
  always_comb begin
    scan_next = scan;
    if (advance) begin
      scan_next = snap;
      if (in_eof) begin
        scan_next.count     = '0;
        scan_next.recent    = '0;
        scan_next.shar_seen = 1'b0;
        scan_next.uu_state  = UuSkip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready) begin
      in_byte    <= s_tdata;
      in_present <= s_tuser;
      in_eof     <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    scan.head <= scan_next.head;
    if (rst) begin
      scan.count     <= '0;
      scan.recent    <= '0;
      scan.shar_seen <= 1'b0;
      scan.uu_state  <= UuSkip;
    end else begin
      scan.count     <= scan_next.count;
      scan.recent    <= scan_next.recent;
      scan.shar_seen <= scan_next.shar_seen;
      scan.uu_state  <= scan_next.uu_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_eof) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && in_eof) begin
      out_code  <= code;
      out_count <= snap.count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OutPadW{1'b0}}, out_count, out_code};

endmodule

/* hdl/cfsc_checker.sv */
// ----------------------------------------------------------------------------
// cfsc_checker
// Port-level checks for the signature classifier, bound to the top level.
// ----------------------------------------------------------------------------
module cfsc_checker import cfsc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OutTdataW-1:0] m_tdata
);

  // no result left over after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // count saturates at the window size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[CodeW+CountW-1:CodeW] <= CountW'(WindowBytes))
    else $error("bytes_examined beyond window");

  // a gzip verdict needs its two magic bytes counted
  a_gzip_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[CodeW-1:0] == FMT_GZIP |-> m_tdata[CodeW+CountW-1:CodeW] >= CountW'(2))
    else $error("gzip reported on a short head");

  // codes past cpio newc never appear
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[CodeW-1:0] <= FMT_CPIO)
    else $error("format_code out of range");

endmodule

bind compressed_format_signature_classifier_core cfsc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/classifier_verdict_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// classifier_verdict_check
// Watches both request channels of the signature classifier, keeps its own
// scan of each file head, forms the expected format verdict at every
// end-of-file request and compares it with the result requests.
// ----------------------------------------------------------------------------
module classifier_verdict_check import cfsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,     // [7:0] data_byte
  input  logic                 s_tuser,     // byte_present
  input  logic                 s_tlast,     // end_of_file
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [OutTdataW-1:0] m_tdata,     // [3:0] format_code, [16:4] bytes_examined
  output int                   mismatches,
  output int                   outstanding
);

  // magic numbers, byte i of the file at bits [8*i +: 8]
  localparam logic [15:0] GzipMagic  = 16'h8B_1F;
  localparam logic [23:0] Bzip2Magic = 24'h68_5A_42;
  localparam logic [47:0] XzMagic    = 48'h00_5A_58_7A_37_FD;
  localparam logic [31:0] LzipMagic  = 32'h50_49_5A_4C;
  localparam logic [31:0] Lz4Magic   = 32'h18_4D_22_04;
  localparam logic [71:0] LzopMagic  = 72'h0A_1A_0A_0D_00_4F_5A_4C_89;
  localparam logic [15:0] SharBang   = 16'h21_23;
  localparam logic [63:0] ArMagic    = 64'h0A_3E_68_63_72_61_3C_21;
  localparam logic [47:0] CpioMagic  = 48'h31_30_37_30_37_30;
  localparam logic [47:0] BeginWord  = 48'h20_6E_69_67_65_62;

  typedef struct packed {
    fmt_t              code;
    logic [CountW-1:0] examined;
  } verdict_t;

  verdict_t verdict_q[$];

  int unsigned scanned;
  logic [7:0]  head_seen [HeadBytes];
  logic [23:0] last3;
  logic        shar_flag;
  uu_state_t   uu_pos;

  function automatic void clear_scan();
    scanned   = 0;
    last3     = '0;
    shar_flag = 1'b0;
    uu_pos    = UuSkip;
    foreach (head_seen[i]) head_seen[i] = 8'h00;
  endfunction

  function automatic logic white(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [31:0] tail4;
    if (scanned < HeadBytes) head_seen[scanned] = b;
    tail4 = {last3, b};
    if (scanned >= 3 && tail4 == SharWord) shar_flag = 1'b1;
    last3 = tail4[23:0];
    if (uu_pos == UuSkip) begin
      if (!white(b)) uu_pos = (b == BeginWord[7:0]) ? uu_state_t'(1) : UuFail;
    end else if (uu_pos < UuDone) begin
      uu_pos = (b == BeginWord[8*uu_pos +: 8]) ? uu_pos + 3'd1 : UuFail;
    end
    scanned++;
  endfunction

  function automatic logic head_matches(input logic [71:0] sig, input int len);
    if (scanned < len) return 1'b0;
    for (int i = 0; i < len; i++)
      if (head_seen[i] != sig[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // first match in priority order wins
  function automatic fmt_t classify_head();
    logic [31:0] dict;
    if (head_matches(72'(GzipMagic), 2)) return FMT_GZIP;
    if (head_matches(72'(Bzip2Magic), 3)) return FMT_BZIP2;
    if (head_matches(72'(XzMagic), 6)) return FMT_XZ;
    if (head_matches(72'(LzipMagic), 4)) return FMT_LZIP;
    if (head_matches(72'(Lz4Magic), 4)) return FMT_LZ4;
    if (scanned >= 13 && head_seen[0] <= LzmaPropsMax) begin
      dict = {head_seen[4], head_seen[3], head_seen[2], head_seen[1]};
      if (dict >= LzmaDictMin && dict <= LzmaDictMax) return FMT_LZMA;
    end
    if (head_matches(LzopMagic, 9)) return FMT_LZOP;
    if (scanned >= 10 && head_matches(72'(SharBang), 2) && shar_flag) return FMT_SHAR;
    if (uu_pos == UuDone) return FMT_UUENC;
    if (head_matches(72'(ArMagic), 8)) return FMT_AR;
    if (head_matches(72'(CpioMagic), 6)) return FMT_CPIO;
    return FMT_NONE;
  endfunction

  always @(posedge clk) begin
    verdict_t          want;
    logic [CodeW-1:0]  got_code;
    logic [CountW-1:0] got_count;
    if (rst) begin
      verdict_q.delete();
      clear_scan();
    end else begin
      // results first: a result never belongs to a request taken at this edge
      if (m_tvalid && m_tready) begin
        got_code  = m_tdata[CodeW-1:0];
        got_count = m_tdata[CodeW +: CountW];
        if (verdict_q.size() == 0) begin
          $error("unexpected result request: tdata %h", m_tdata);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (got_code != want.code) begin
            $error("format_code: expected %0d, got %0d", want.code, got_code);
            mismatches++;
          end
          if (got_count != want.examined) begin
            $error("bytes_examined: expected %0d, got %0d", want.examined, got_count);
            mismatches++;
          end
          if (m_tdata[OutTdataW-1:CodeW+CountW] != '0) begin
            $error("tdata padding: expected 0, got %h", m_tdata[OutTdataW-1:CodeW+CountW]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser && scanned < WindowBytes) absorb_byte(s_tdata);
        if (s_tlast) begin
          verdict_q.push_back('{code: classify_head(), examined: scanned[CountW-1:0]});
          clear_scan();
        end
      end
    end
    outstanding = verdict_q.size();
  end

endmodule

/* tb/compressed_format_signature_classifier_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compressed_format_signature_classifier_core_test
// Streams file heads into the classifier: a short directed set, then random
// files built mostly around real magic numbers, some damaged or truncated.
// Verdicts are checked by classifier_verdict_check; this module drives
// stimulus and gives the result.
// ----------------------------------------------------------------------------
module compressed_format_signature_classifier_core_test;
  import cfsc_pkg::*;

  // every input holds a known value from time zero
  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata  = 8'h00;   // [7:0] data_byte
  logic                 s_tuser  = 1'b0;    // byte_present
  logic                 s_tlast  = 1'b0;    // end_of_file
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutTdataW-1:0] m_tdata;            // [3:0] format_code, [16:4] bytes_examined

  int mismatches;
  int outstanding;

  // idle odds in percent per cycle, changed between phases
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  // long receiver hold-off, requested by the stimulus, timed by the receiver
  bit hold_req  = 1'b0;
  int hold_left = 0;

  int         sent_items = 0;
  logic [7:0] file_q[$];

  always #1 clk = ~clk;

  compressed_format_signature_classifier_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  classifier_verdict_check verdicts (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver: random back-pressure, or a long solid hold-off so the
  // result register stays full and end-of-file requests back up.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // One request. Called at a falling edge, returns at the falling edge after
  // the rising edge that took it, so tvalid gets one assignment per step.
  task automatic send_request(input logic [7:0] b, input logic present, input logic eof);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= present;
    s_tlast  <= eof;
    do @(posedge clk); while (!s_tready);
    sent_items++;
    @(negedge clk);
  endtask

  // Sends file_q as one file. Bare fillers without end marker land anywhere;
  // the file closes either on its last byte or with a bare end marker.
  task automatic send_file();
    bit close_on_byte;
    close_on_byte = (file_q.size() > 0) && ($urandom_range(0, 1) == 1);
    foreach (file_q[i]) begin
      if ($urandom_range(0, 19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(file_q[i], 1'b1, close_on_byte && (i == file_q.size() - 1));
    end
    if (!close_on_byte) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endtask

  task automatic add_noise(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) file_q.push_back(8'($urandom));
  endtask

  task automatic add_space();
    case ($urandom_range(0, 3))
      0:       file_q.push_back(8'h20);
      1:       file_q.push_back(8'h09);
      2:       file_q.push_back(8'h0A);
      default: file_q.push_back(8'h0D);
    endcase
  endtask

  // Builds a file head around one format; FMT_NONE gives plain noise.
  // One file in five is damaged: cut short or one early byte flipped.
  task automatic build_file(input fmt_t kind);
    logic [31:0] dict;
    logic [7:0]  props;
    int          idx;
    file_q.delete();
    case (kind)
      FMT_GZIP: begin
        file_q.push_back(8'h1F);
        file_q.push_back(8'h8B);
        add_noise(0, 8);
      end
      FMT_BZIP2: begin
        add_text("BZh");
        add_noise(0, 8);
      end
      FMT_XZ: begin
        file_q.push_back(8'hFD);
        add_text("7zXZ");
        file_q.push_back(8'h00);
        add_noise(0, 8);
      end
      FMT_LZIP: begin
        add_text("LZIP");
        add_noise(0, 8);
      end
      FMT_LZ4: begin
        file_q.push_back(8'h04);
        file_q.push_back(8'h22);
        file_q.push_back(8'h4D);
        file_q.push_back(8'h18);
        add_noise(0, 8);
      end
      FMT_LZMA: begin
        // dictionary size and props at, just past and inside their limits
        case ($urandom_range(0, 5))
          0:       dict = LzmaDictMin - 1;
          1:       dict = LzmaDictMin;
          2:       dict = LzmaDictMax;
          3:       dict = LzmaDictMax + 1;
          default: dict = $urandom_range(LzmaDictMin, LzmaDictMax);
        endcase
        case ($urandom_range(0, 3))
          0:       props = LzmaPropsMax;
          1:       props = LzmaPropsMax + 8'd1;
          2:       props = 8'($urandom);
          default: props = 8'($urandom_range(0, LzmaPropsMax));
        endcase
        file_q.push_back(props);
        for (int i = 0; i < 4; i++) file_q.push_back(dict[8*i +: 8]);
        add_noise(7, 14);
      end
      FMT_LZOP: begin
        // short tails keep some of these out of the lzma rule's reach
        file_q.push_back(8'h89);
        add_text("LZO");
        file_q.push_back(8'h00);
        file_q.push_back(8'h0D);
        file_q.push_back(8'h0A);
        file_q.push_back(8'h1A);
        file_q.push_back(8'h0A);
        add_noise(0, 6);
      end
      FMT_SHAR: begin
        add_text("#!");
        add_noise(0, 6);
        if ($urandom_range(0, 3) != 0) add_text("shar");
        add_noise(0, 6);
      end
      FMT_UUENC: begin
        repeat ($urandom_range(0, 4)) add_space();
        add_text("begin ");
        add_noise(0, 8);
      end
      FMT_AR: begin
        add_text("!<arch>\n");
        add_noise(0, 8);
      end
      FMT_CPIO: begin
        add_text("070701");
        add_noise(0, 8);
      end
      default: add_noise(0, 20);
    endcase
    if (file_q.size() > 0 && $urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        idx = $urandom_range(0, file_q.size() - 1);
        while (file_q.size() > idx) void'(file_q.pop_back());
      end else begin
        idx = $urandom_range(0, (file_q.size() < 10 ? file_q.size() : 10) - 1);
        file_q[idx] ^= 8'($urandom_range(1, 255));
      end
    end
  endtask

  task automatic run_random(input int budget);
    int stop_at;
    stop_at = sent_items + budget;
    while (sent_items < stop_at) begin
      build_file(fmt_t'($urandom_range(FMT_NONE, FMT_CPIO)));
      send_file();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // phase 1: slow-ish sender, mostly stalled receiver
    src_idle_pct  = 35;
    sink_idle_pct = 79;

    // empty file: a bare end marker alone
    send_request(8'hFF, 1'b0, 1'b1);
    // all-zero and all-one bytes around a bare filler, closed on a byte
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hAA, 1'b0, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h55, 1'b1, 1'b1);
    // shortest gzip, end marker on its last byte
    send_request(8'h1F, 1'b1, 1'b0);
    send_request(8'h8B, 1'b1, 1'b1);
    // lz4 magic, closed by a bare end marker
    file_q = '{8'h04, 8'h22, 8'h4D, 8'h18};
    foreach (file_q[i]) send_request(file_q[i], 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    // uuencode header behind every kind of leading whitespace
    file_q.delete();
    file_q = '{8'h0D, 8'h0A, 8'h09, 8'h20};
    add_text("begin ");
    foreach (file_q[i]) send_request(file_q[i], 1'b1, i == file_q.size() - 1);

    run_random(410);

    // phase 2: roles swapped
    src_idle_pct  = 79;
    sink_idle_pct = 35;
    run_random(410);

    // phase 3: no idling; first a long hold-off against a stream of tiny files
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req      = 1'b1;
    repeat (40) begin
      file_q.delete();
      add_noise(0, 2);
      send_file();
    end
    run_random(410);

    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("compressed_format_signature_classifier_core test passed");
    end else begin
      $display("compressed_format_signature_classifier_core test failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest passing run
  initial begin
    #400000;
    $display("compressed_format_signature_classifier_core test failed");
    $finish;
  end

endmodule

/* compressed_format_signature_classifier_core.f */
hdl/cfsc_pkg.sv
hdl/cfsc_match.sv
hdl/compressed_format_signature_classifier_core.sv
hdl/cfsc_checker.sv
tb/classifier_verdict_check.sv
tb/compressed_format_signature_classifier_core_test.sv
